### rtl/core/thal_pkg.sv
// Shared types and constants for the threshold alarm ring log.
// No dependencies.
package thal_pkg;

	localparam logic [1:0] ACT_CHECK = 2'd0;
	localparam logic [1:0] ACT_QUERY = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [1:0] KIND_LIVE   = 2'd0;
	localparam logic [1:0] KIND_REPLAY = 2'd1;
	localparam logic [1:0] KIND_EMPTY  = 2'd2;

	localparam logic [1:0] REG_LIMIT0 = 2'd0;
	localparam logic [1:0] REG_LIMIT1 = 2'd1;
	localparam logic [1:0] REG_MODE   = 2'd2;

	localparam logic [7:0] MODE_REPORT = 8'd1;
	localparam logic [7:0] MODE_RESET  = 8'd2;

	typedef enum logic [1:0] {
		SRC_LIVE0,
		SRC_LIVE1,
		SRC_REPLAY,
		SRC_EMPTY
	} out_src_t;

	typedef struct packed {
		logic [31:0] stamp;
		logic        chan;
		logic [31:0] thr;
		logic [31:0] val;
	} rec_t;

	typedef struct packed {
		logic     load_item;
		logic     clear;
		logic     store;
		logic     store_ch;
		logic     start_rd;
		logic     mem_rd;
		logic     next_rd;
		logic     out_load;
		out_src_t out_src;
	} cmd_t;

	typedef struct packed {
		logic hit0;
		logic hit1;
		logic live;
		logic empty;
		logic last_rd;
	} sts_t;

endpackage

### rtl/core/thal_dp.sv
// Datapath: config registers, item latch, threshold compare, record memory,
// ring pointers and output payload register. Depends on thal_pkg.
module thal_dp #(
	parameter int LOG_DEPTH = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic [95:0]          s_tdata,
	input  thal_pkg::cmd_t       cmd,
	output thal_pkg::sts_t       sts,
	output logic [103:0]         m_tdata,
	output logic [1:0]           m_tuser,
	output logic                 m_tlast
);

	localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int CW = $clog2(LOG_DEPTH + 1);
	localparam int SW = $clog2(2 * LOG_DEPTH);

	logic signed [31:0] limit0_q, limit1_q;
	logic [7:0]         mode_q;
	logic signed [31:0] sample0_q, sample1_q;
	logic [31:0]        time_q;

	logic [AW-1:0] slot_q, rd_ptr_q, start_idx;
	logic [CW-1:0] count_q, rem_q;
	logic [SW-1:0] start_sum;

	thal_pkg::rec_t mem_q [LOG_DEPTH];
	thal_pkg::rec_t rd_data_q, wr_rec;

	logic [31:0] out_stamp_q, out_thr_q, out_val_q;
	logic        out_chan_q, out_last_q;
	logic [1:0]  out_kind_q;
	logic        out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit0_q <= '0;
			limit1_q <= '0;
			mode_q   <= thal_pkg::MODE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				thal_pkg::REG_LIMIT0: limit0_q <= cfg_data;
				thal_pkg::REG_LIMIT1: limit1_q <= cfg_data;
				thal_pkg::REG_MODE:   mode_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			sample0_q <= s_tdata[31:0];
			sample1_q <= s_tdata[63:32];
			time_q    <= s_tdata[95:64];
		end
	end

	assign sts.hit0    = (limit0_q > 32'sd0) && (sample0_q > limit0_q);
	assign sts.hit1    = (limit1_q > 32'sd0) && (sample1_q > limit1_q);
	assign sts.live    = (mode_q == thal_pkg::MODE_REPORT);
	assign sts.empty   = (count_q == '0);
	assign sts.last_rd = (rem_q == CW'(1));

	// oldest entry: slot - count, modulo depth
	assign start_sum = SW'(slot_q) + SW'(LOG_DEPTH) - SW'(count_q);
	assign start_idx = (start_sum >= SW'(LOG_DEPTH)) ? AW'(start_sum - SW'(LOG_DEPTH))
	                                                 : AW'(start_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			count_q  <= '0;
			rd_ptr_q <= '0;
			rem_q    <= '0;
		end else begin
			if (cmd.clear) begin
				slot_q  <= '0;
				count_q <= '0;
			end else if (cmd.store) begin
				slot_q <= (slot_q == AW'(LOG_DEPTH - 1)) ? '0 : slot_q + AW'(1);
				if (count_q != CW'(LOG_DEPTH))
					count_q <= count_q + CW'(1);
			end
			if (cmd.start_rd) begin
				rd_ptr_q <= start_idx;
				rem_q    <= count_q;
			end else if (cmd.next_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(LOG_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
				rem_q    <= rem_q - CW'(1);
			end
		end
	end

	always_comb begin
		wr_rec.stamp = time_q;
		wr_rec.chan  = cmd.store_ch;
		wr_rec.thr   = cmd.store_ch ? limit1_q : limit0_q;
		wr_rec.val   = cmd.store_ch ? sample1_q : sample0_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.store)
			mem_q[slot_q] <= wr_rec;
		if (cmd.mem_rd)
			rd_data_q <= mem_q[rd_ptr_q];
	end

	always_comb begin
		case (cmd.out_src)
			thal_pkg::SRC_LIVE0:  out_last = !sts.hit1;
			thal_pkg::SRC_REPLAY: out_last = sts.last_rd;
			default:              out_last = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_last_q <= out_last;
			case (cmd.out_src)
				thal_pkg::SRC_LIVE0: begin
					out_kind_q  <= thal_pkg::KIND_LIVE;
					out_stamp_q <= time_q;
					out_chan_q  <= 1'b0;
					out_thr_q   <= limit0_q;
					out_val_q   <= sample0_q;
				end
				thal_pkg::SRC_LIVE1: begin
					out_kind_q  <= thal_pkg::KIND_LIVE;
					out_stamp_q <= time_q;
					out_chan_q  <= 1'b1;
					out_thr_q   <= limit1_q;
					out_val_q   <= sample1_q;
				end
				thal_pkg::SRC_REPLAY: begin
					out_kind_q  <= thal_pkg::KIND_REPLAY;
					out_stamp_q <= rd_data_q.stamp;
					out_chan_q  <= rd_data_q.chan;
					out_thr_q   <= rd_data_q.thr;
					out_val_q   <= rd_data_q.val;
				end
				default: begin
					out_kind_q  <= thal_pkg::KIND_EMPTY;
					out_stamp_q <= '0;
					out_chan_q  <= 1'b0;
					out_thr_q   <= '0;
					out_val_q   <= '0;
				end
			endcase
		end
	end

	assign m_tdata = {7'd0, out_val_q, out_thr_q, out_chan_q, out_stamp_q};
	assign m_tuser = out_kind_q;
	assign m_tlast = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(LOG_DEPTH))
		else $error("entry count above depth");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q < AW'(LOG_DEPTH) || AW'(LOG_DEPTH) == '0)
		else $error("write slot out of range");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (count_q == '0) && (slot_q == '0))
		else $error("clear did not empty the log");

	a_replay_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && cmd.out_src == thal_pkg::SRC_REPLAY) |-> (rem_q != '0))
		else $error("replay beyond stored records");

endmodule

### rtl/core/thal_ctrl.sv
// Controller FSM: sequences check, query and clear items, owns the
// output valid flag. Depends on thal_pkg.
module thal_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  logic [1:0]     action,
	input  logic           m_tready,
	input  thal_pkg::sts_t sts,
	output logic           s_tready,
	output logic           m_tvalid,
	output thal_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK0,
		ST_CHK1,
		ST_NONE,
		ST_READ,
		ST_SEND
	} state_t;

	state_t state_q, state_d;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					unique case (action)
						thal_pkg::ACT_CHECK: state_d = ST_CHK0;
						thal_pkg::ACT_QUERY: begin
							if (sts.empty) begin
								state_d = ST_NONE;
							end else begin
								cmd.start_rd = 1'b1;
								state_d      = ST_READ;
							end
						end
						thal_pkg::ACT_CLEAR: cmd.clear = 1'b1;
						default: ;
					endcase
				end
			end
			ST_CHK0: begin
				if (!sts.hit0) begin
					state_d = ST_CHK1;
				end else if (!sts.live) begin
					cmd.store = 1'b1;
					state_d   = ST_CHK1;
				end else if (out_free) begin
					cmd.store    = 1'b1;
					cmd.out_load = 1'b1;
					cmd.out_src  = thal_pkg::SRC_LIVE0;
					state_d      = ST_CHK1;
				end
			end
			ST_CHK1: begin
				cmd.store_ch = 1'b1;
				cmd.out_src  = thal_pkg::SRC_LIVE1;
				if (!sts.hit1) begin
					state_d = ST_IDLE;
				end else if (!sts.live) begin
					cmd.store = 1'b1;
					state_d   = ST_IDLE;
				end else if (out_free) begin
					cmd.store    = 1'b1;
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_NONE: begin
				cmd.out_src = thal_pkg::SRC_EMPTY;
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_READ: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_SEND;
			end
			ST_SEND: begin
				cmd.out_src = thal_pkg::SRC_REPLAY;
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.next_rd  = 1'b1;
					state_d      = sts.last_rd ? ST_IDLE : ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("output register overwritten while stalled");

	a_query_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_rd |-> !sts.empty)
		else $error("replay started on empty log");

endmodule

### rtl/core/threshold_alarm_ring_log.sv
// Threshold alarm ring log, top level: controller plus datapath.
// Check: accept, then channel 0, then channel 1; a live result is registered on a hit in report mode.
// Query: accept, then a memory read and an output load for each stored record, oldest
// first; an empty log gives one result. Clear and unused actions finish on acceptance.
// Output stalls hold the sequencer in place.
// Reset: log empty, limits 0, mode 2 (live reports off); record memory contents not cleared.
module threshold_alarm_ring_log #(
	parameter int LOG_DEPTH = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [95:0]   s_tdata,   // sample0, sample1, time_now
	input  logic [1:0]    s_tuser,   // action
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [103:0]  m_tdata,   // stamp, channel, threshold_value, measured_value, zero pad
	output logic [1:0]    m_tuser,   // kind
	output logic          m_tlast
);

	thal_pkg::cmd_t cmd;
	thal_pkg::sts_t sts;

	thal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.action   (s_tuser),
		.m_tready (m_tready),
		.sts      (sts),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	thal_dp #(
		.LOG_DEPTH (LOG_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
